/* hdl/plg_pkg.sv */
// ----------------------------------------------------------------------------
// plg_pkg
// Shared types and constants for the probabilistic logic gate.
// ----------------------------------------------------------------------------
package plg_pkg;

   localparam int TBL_ADDR_W   = 8;   // 16 rows by 16 columns
   localparam int TBL_DIM_W    = 4;
   localparam int WEIGHT_W     = 8;
   localparam int SUM_W        = 12;  // 16 * 255 fits in 12 bits
   localparam int ALU_W        = SUM_W + 1;
   localparam int NODE_IDX_W   = 5;
   localparam int LIST_ENTRIES = 4;
   localparam int LIST_W       = NODE_IDX_W * LIST_ENTRIES;
   localparam int COUNT_W      = 3;
   localparam int DRAW_W       = 31;
   localparam int DRAW_CNT_W   = 5;
   localparam int MASK_W       = 32;
   localparam int STATES_W     = 32;
   localparam int CSR_IDX_W    = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_NODE_LIST  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_NODE_LIST = 2'd3;

   // Request item opcodes.
   localparam logic OP_EVALUATE = 1'b0;
   localparam logic OP_LOAD     = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SUM_RD   = 7'b0000010,
      ST_SUM_ACC  = 7'b0000100,
      ST_DIV      = 7'b0001000,
      ST_WALK_RD  = 7'b0010000,
      ST_WALK_CMP = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             borrow;
   } alu_rsp_type;

endpackage

/* hdl/probabilistic_logic_gate.sv */
// ----------------------------------------------------------------------------
// probabilistic_logic_gate
// Stochastic gate: gathers input node bits into a row index, draws a column
// of that row by its weights and reports the column bits as a node mask.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  op, node_states, random_draw,
//                                              load_row, load_column, load_weight
//   rsp      out        rsp_valid / rsp_stall  set_mask, chosen_column, row_used
//   csr      in         csr_write              csr_index, csr_wdata
//
// A load transfer writes the table in its accept cycle and yields no result.
// An evaluate makes two passes over the table read port, one to sum the used
// columns of the row and one to walk to the chosen column, plus a restoring
// modulo of one bit per cycle, all through one shared adder.
// req_stall is high while an evaluate is in work. A finished result waits in
// the output register, and the gate holds in its last step while rsp_stall
// blocks a full output register. Synchronous reset sets the table to all
// ones through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module probabilistic_logic_gate #(
   parameter int NODE_COUNT  = 32,
   parameter int MAX_INPUTS  = 4,
   parameter int MAX_OUTPUTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [plg_pkg::STATES_W-1:0]       req_node_states,
   input  logic [plg_pkg::DRAW_W-1:0]         req_random_draw,
   input  logic [plg_pkg::TBL_DIM_W-1:0]      req_load_row,
   input  logic [plg_pkg::TBL_DIM_W-1:0]      req_load_column,
   input  logic [plg_pkg::WEIGHT_W-1:0]       req_load_weight,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [plg_pkg::MASK_W-1:0]         rsp_set_mask,
   output logic [plg_pkg::TBL_DIM_W-1:0]      rsp_chosen_column,
   output logic [plg_pkg::TBL_DIM_W-1:0]      rsp_row_used,

   input  logic                               csr_write,
   input  logic [plg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plg_pkg::LIST_W-1:0]         csr_wdata
);

   localparam int IN_HI  = (MAX_INPUTS  < plg_pkg::LIST_ENTRIES) ?
                           ((MAX_INPUTS  < 1) ? 1 : MAX_INPUTS)  : plg_pkg::LIST_ENTRIES;
   localparam int OUT_HI = (MAX_OUTPUTS < plg_pkg::LIST_ENTRIES) ?
                           ((MAX_OUTPUTS < 1) ? 1 : MAX_OUTPUTS) : plg_pkg::LIST_ENTRIES;
   localparam int NW = plg_pkg::NODE_IDX_W;
   localparam int DW = plg_pkg::TBL_DIM_W;

   // Configuration registers.
   logic [plg_pkg::COUNT_W-1:0] in_count_ff;
   logic [plg_pkg::COUNT_W-1:0] out_count_ff;
   logic [plg_pkg::LIST_W-1:0]  in_list_ff;
   logic [plg_pkg::LIST_W-1:0]  out_list_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= plg_pkg::COUNT_W'(1);
         out_count_ff <= plg_pkg::COUNT_W'(1);
         in_list_ff   <= '0;
         out_list_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            plg_pkg::CSR_INPUT_COUNT: begin
               in_count_ff <= csr_wdata[plg_pkg::COUNT_W-1:0];
            end
            plg_pkg::CSR_OUTPUT_COUNT: begin
               out_count_ff <= csr_wdata[plg_pkg::COUNT_W-1:0];
            end
            plg_pkg::CSR_INPUT_NODE_LIST: begin
               in_list_ff <= csr_wdata;
            end
            plg_pkg::CSR_OUTPUT_NODE_LIST: begin
               out_list_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Effective counts, saturated to the supported range.
   logic [plg_pkg::COUNT_W-1:0] nin;
   logic [plg_pkg::COUNT_W-1:0] nout;
   logic [DW-1:0]               last_col;

   always_comb begin
      nin = in_count_ff;
      if (nin == '0) begin
         nin = plg_pkg::COUNT_W'(1);
      end
      if (int'(nin) > IN_HI) begin
         nin = plg_pkg::COUNT_W'(IN_HI);
      end
      nout = out_count_ff;
      if (nout == '0) begin
         nout = plg_pkg::COUNT_W'(1);
      end
      if (int'(nout) > OUT_HI) begin
         nout = plg_pkg::COUNT_W'(OUT_HI);
      end
      last_col = DW'((5'd1 << nout) - 5'd1);
   end

   // Row index from the input node bits, first node as the MSB.
   logic [DW-1:0] row_gather;
   logic [NW-1:0] in_node;

   always_comb begin
      row_gather = '0;
      in_node    = '0;
      for (int i = 0; i < plg_pkg::LIST_ENTRIES; i++) begin
         in_node = in_list_ff[i*NW +: NW];
         if (i < int'(nin)) begin
            row_gather = {row_gather[DW-2:0],
                          (int'(in_node) < NODE_COUNT) ? req_node_states[in_node] : 1'b0};
         end
      end
   end

   // Sequencer registers.
   plg_pkg::state_type            state_ff, state_in;
   logic [DW-1:0]                 row_ff, row_in;
   logic [DW-1:0]                 col_ff, col_in;
   logic [plg_pkg::SUM_W-1:0]     acc_ff, acc_in;    // row sum
   logic [plg_pkg::SUM_W-1:0]     rem_ff, rem_in;    // remainder, then walk residue
   logic [plg_pkg::DRAW_W-1:0]    draw_ff, draw_in;
   logic [plg_pkg::DRAW_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [plg_pkg::MASK_W-1:0]    mask_ff, mask_in;
   logic [DW-1:0]                 out_col_ff, out_col_in;
   logic [DW-1:0]                 out_row_ff, out_row_in;

   logic                          req_xfer;
   logic                          out_free;
   logic                          tbl_wr;
   logic [plg_pkg::WEIGHT_W-1:0]  tbl_weight;
   plg_pkg::alu_req_type          alu_req;
   plg_pkg::alu_rsp_type          alu_rsp;
   logic [plg_pkg::MASK_W-1:0]    mask_calc;
   logic [NW-1:0]                 out_node;

   assign req_stall = (state_ff != plg_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign tbl_wr    = req_xfer && (req_op == plg_pkg::OP_LOAD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   plg_wtable u_wtable (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (tbl_wr),
      .wr_addr   ({req_load_row, req_load_column}),
      .wr_weight (req_load_weight),
      .rd_addr   ({row_ff, col_ff}),
      .rd_weight (tbl_weight)
   );

   // The single adder serves all three phases.
   always_comb begin
      alu_req.sub = 1'b1;
      alu_req.a   = {1'b0, rem_ff};
      alu_req.b   = {{(plg_pkg::ALU_W-plg_pkg::WEIGHT_W){1'b0}}, tbl_weight};
      case (state_ff)
         plg_pkg::ST_SUM_ACC: begin
            alu_req.sub = 1'b0;
            alu_req.a   = {1'b0, acc_ff};
         end
         plg_pkg::ST_DIV: begin
            alu_req.a = {rem_ff, draw_ff[plg_pkg::DRAW_W-1]};
            alu_req.b = {1'b0, acc_ff};
         end
         default: begin
         end
      endcase
   end

   plg_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // Output mask from the chosen column bits.
   always_comb begin
      mask_calc = '0;
      out_node  = '0;
      for (int i = 0; i < plg_pkg::LIST_ENTRIES; i++) begin
         out_node = out_list_ff[i*NW +: NW];
         if (i < int'(nout) && int'(out_node) < NODE_COUNT && col_ff[i]) begin
            mask_calc = mask_calc | (plg_pkg::MASK_W'(1) << out_node);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      draw_in      = draw_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mask_in      = mask_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      case (state_ff)
         plg_pkg::ST_IDLE: begin
            if (req_xfer && req_op == plg_pkg::OP_EVALUATE) begin
               row_in   = row_gather;
               col_in   = '0;
               acc_in   = '0;
               draw_in  = req_random_draw;
               state_in = plg_pkg::ST_SUM_RD;
            end
         end
         plg_pkg::ST_SUM_RD: begin
            state_in = plg_pkg::ST_SUM_ACC;
         end
         plg_pkg::ST_SUM_ACC: begin
            acc_in = alu_rsp.res[plg_pkg::SUM_W-1:0];
            if (col_ff == last_col) begin
               rem_in   = '0;
               cnt_in   = plg_pkg::DRAW_CNT_W'(plg_pkg::DRAW_W - 1);
               state_in = plg_pkg::ST_DIV;
            end else begin
               col_in   = col_ff + DW'(1);
               state_in = plg_pkg::ST_SUM_RD;
            end
         end
         plg_pkg::ST_DIV: begin
            // Restoring step: keep the difference when it does not go negative.
            if (alu_rsp.borrow) begin
               rem_in = alu_req.a[plg_pkg::SUM_W-1:0];
            end else begin
               rem_in = alu_rsp.res[plg_pkg::SUM_W-1:0];
            end
            draw_in = {draw_ff[plg_pkg::DRAW_W-2:0], 1'b0};
            cnt_in  = cnt_ff - plg_pkg::DRAW_CNT_W'(1);
            if (cnt_ff == '0) begin
               col_in   = '0;
               state_in = plg_pkg::ST_WALK_RD;
            end
         end
         plg_pkg::ST_WALK_RD: begin
            state_in = plg_pkg::ST_WALK_CMP;
         end
         plg_pkg::ST_WALK_CMP: begin
            // Move on while the residue is strictly above this column's weight.
            if (col_ff != last_col && !alu_rsp.borrow && alu_rsp.res != '0) begin
               rem_in   = alu_rsp.res[plg_pkg::SUM_W-1:0];
               col_in   = col_ff + DW'(1);
               state_in = plg_pkg::ST_WALK_RD;
            end else begin
               state_in = plg_pkg::ST_DONE;
            end
         end
         plg_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mask_in      = mask_calc;
               out_col_in   = col_ff;
               out_row_in   = row_ff;
               state_in     = plg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      draw_ff    <= draw_in;
      mask_ff    <= mask_in;
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_set_mask      = mask_ff;
   assign rsp_chosen_column = out_col_ff;
   assign rsp_row_used      = out_row_ff;

endmodule

/* hdl/plg_alu.sv */
// ----------------------------------------------------------------------------
// plg_alu
// Shared add/subtract unit used for the row sum, the modulo steps and the
// column walk.
// ----------------------------------------------------------------------------
module plg_alu (
   input  plg_pkg::alu_req_type req,
   output plg_pkg::alu_rsp_type rsp
);

   logic [plg_pkg::ALU_W:0] full;

   always_comb begin
      if (req.sub) begin
         full = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         full = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.res    = full[plg_pkg::ALU_W-1:0];
      rsp.borrow = full[plg_pkg::ALU_W];
   end

endmodule

/* hdl/plg_wtable.sv */
// ----------------------------------------------------------------------------
// plg_wtable
// 256-byte weight table with one write and one registered read port.
// Entries never written since reset read as one.
// ----------------------------------------------------------------------------
module plg_wtable (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [plg_pkg::TBL_ADDR_W-1:0]    wr_addr,
   input  logic [plg_pkg::WEIGHT_W-1:0]      wr_weight,
   input  logic [plg_pkg::TBL_ADDR_W-1:0]    rd_addr,
   output logic [plg_pkg::WEIGHT_W-1:0]      rd_weight
);

   localparam int DEPTH = 1 << plg_pkg::TBL_ADDR_W;

   logic [plg_pkg::WEIGHT_W-1:0] mem_ff [0:DEPTH-1];
   logic [DEPTH-1:0]             valid_ff;
   logic [plg_pkg::WEIGHT_W-1:0] rd_data_ff;
   logic                         rd_valid_ff;
   logic [plg_pkg::WEIGHT_W-1:0] weight_in;

   // A zero weight is stored as one so that no row sum is ever zero.
   assign weight_in = (wr_weight == '0) ? plg_pkg::WEIGHT_W'(1) : wr_weight;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= weight_in;
      end
      rd_data_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_weight = rd_valid_ff ? rd_data_ff : plg_pkg::WEIGHT_W'(1);

endmodule

/* tb/tb_probabilistic_logic_gate.sv */
// ----------------------------------------------------------------------------
// tb_probabilistic_logic_gate
// Self-checking bench for the stochastic gate. A queue-fed driver offers
// weight loads and evaluates. A shadow weight table and register copy predict
// the row, the chosen column and the node mask of every evaluate. A monitor
// checks each result transfer in order. The run steps through several
// register settings and through the count extremes. It varies the idling on
// both channels and holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_probabilistic_logic_gate;

   localparam int NODE_COUNT     = 32;
   localparam int MAX_INPUTS     = 4;
   localparam int MAX_OUTPUTS    = 4;
   localparam int SEGMENT_ITEMS  = 184;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic                          op;
      logic [plg_pkg::STATES_W-1:0]  node_states;
      logic [plg_pkg::DRAW_W-1:0]    random_draw;
      logic [plg_pkg::TBL_DIM_W-1:0] load_row;
      logic [plg_pkg::TBL_DIM_W-1:0] load_column;
      logic [plg_pkg::WEIGHT_W-1:0]  load_weight;
   } gate_item_type;

   typedef struct {
      logic [plg_pkg::MASK_W-1:0]    set_mask;
      logic [plg_pkg::TBL_DIM_W-1:0] chosen_column;
      logic [plg_pkg::TBL_DIM_W-1:0] row_used;
   } gate_pick_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_op = plg_pkg::OP_EVALUATE;
   logic [plg_pkg::STATES_W-1:0]  req_node_states = '0;
   logic [plg_pkg::DRAW_W-1:0]    req_random_draw = '0;
   logic [plg_pkg::TBL_DIM_W-1:0] req_load_row = '0;
   logic [plg_pkg::TBL_DIM_W-1:0] req_load_column = '0;
   logic [plg_pkg::WEIGHT_W-1:0]  req_load_weight = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [plg_pkg::MASK_W-1:0]    rsp_set_mask;
   logic [plg_pkg::TBL_DIM_W-1:0] rsp_chosen_column;
   logic [plg_pkg::TBL_DIM_W-1:0] rsp_row_used;
   logic                          csr_write = 1'b0;
   logic [plg_pkg::CSR_IDX_W-1:0] csr_index = plg_pkg::CSR_INPUT_COUNT;
   logic [plg_pkg::LIST_W-1:0]    csr_wdata = '0;

   probabilistic_logic_gate #(
      .NODE_COUNT (NODE_COUNT),
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_OUTPUTS(MAX_OUTPUTS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_node_states  (req_node_states),
      .req_random_draw  (req_random_draw),
      .req_load_row     (req_load_row),
      .req_load_column  (req_load_column),
      .req_load_weight  (req_load_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_set_mask     (rsp_set_mask),
      .rsp_chosen_column(rsp_chosen_column),
      .rsp_row_used     (rsp_row_used),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Shadow state of the gate.
   logic [plg_pkg::WEIGHT_W-1:0] weight_shadow [16][16];
   logic [plg_pkg::COUNT_W-1:0]  in_count_cfg  = 3'd1;
   logic [plg_pkg::COUNT_W-1:0]  out_count_cfg = 3'd1;
   logic [plg_pkg::LIST_W-1:0]   in_list_cfg   = '0;
   logic [plg_pkg::LIST_W-1:0]   out_list_cfg  = '0;

   gate_item_type req_backlog [$];
   gate_pick_type picks_due [$];
   gate_item_type offered_item;
   gate_pick_type arrived_pick;

   int error_count  = 0;
   int eval_count   = 0;
   int load_count   = 0;
   int setting_count = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int holds_asked  = 0;
   int holds_served = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_count(input logic [plg_pkg::COUNT_W-1:0] v,
                                               input int max_p);
      int unsigned hi;
      int unsigned n;
      hi = (max_p < plg_pkg::LIST_ENTRIES) ? max_p : plg_pkg::LIST_ENTRIES;
      if (hi < 1) hi = 1;
      n = 32'(v);
      if (n < 1) n = 1;
      if (n > hi) n = hi;
      return n;
   endfunction

   task automatic queue_item(input gate_item_type item);
      req_backlog = {req_backlog, item};
   endtask

   // Applies one accepted item to the shadow gate; evaluates queue their pick.
   task automatic run_gate_item(input gate_item_type item);
      int unsigned   n_in;
      int unsigned   n_out;
      int unsigned   n_cols;
      int unsigned   row;
      int unsigned   col;
      int unsigned   sum;
      int unsigned   rem;
      int unsigned   node;
      gate_pick_type pick;
      if (item.op == plg_pkg::OP_LOAD) begin
         weight_shadow[item.load_row][item.load_column] =
            (item.load_weight == 0) ? 8'd1 : item.load_weight;
         load_count++;
      end else begin
         n_in   = clamp_count(in_count_cfg, MAX_INPUTS);
         n_out  = clamp_count(out_count_cfg, MAX_OUTPUTS);
         n_cols = 1 << n_out;
         // The first input node lands in the most significant row bit.
         row = 0;
         for (int i = 0; i < n_in; i++) begin
            node = 32'(in_list_cfg[plg_pkg::NODE_IDX_W*i +: plg_pkg::NODE_IDX_W]);
            row  = (row << 1) | ((node < NODE_COUNT) ? item.node_states[node] : 1'b0);
         end
         row = row & 15;
         sum = 0;
         for (int c = 0; c < n_cols; c++) sum += weight_shadow[row][c];
         rem = item.random_draw % sum;
         col = 0;
         while (col < n_cols - 1 && rem > weight_shadow[row][col]) begin
            rem -= weight_shadow[row][col];
            col++;
         end
         pick.set_mask = '0;
         for (int i = 0; i < n_out; i++) begin
            node = 32'(out_list_cfg[plg_pkg::NODE_IDX_W*i +: plg_pkg::NODE_IDX_W]);
            if (node < NODE_COUNT && col[i]) pick.set_mask[node] = 1'b1;
         end
         pick.chosen_column = col[3:0];
         pick.row_used      = row[3:0];
         picks_due = {picks_due, pick};
         eval_count++;
      end
   endtask

   // Driver: a payload stays put until its transfer completes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            run_gate_item(offered_item);
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_item = req_backlog[0];
               req_backlog.delete(0);
               req_valid       <= 1'b1;
               req_op          <= offered_item.op;
               req_node_states <= offered_item.node_states;
               req_random_draw <= offered_item.random_draw;
               req_load_row    <= offered_item.load_row;
               req_load_column <= offered_item.load_column;
               req_load_weight <= offered_item.load_weight;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and output stall control.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (picks_due.size() == 0) begin
               $display("%0t: result transfer with nothing outstanding: mask %h col %0d row %0d",
                        $time, rsp_set_mask, rsp_chosen_column, rsp_row_used);
               error_count++;
            end else begin
               arrived_pick = picks_due[0];
               picks_due.delete(0);
               if (rsp_set_mask !== arrived_pick.set_mask) begin
                  $display("%0t: set_mask expected %h, got %h",
                           $time, arrived_pick.set_mask, rsp_set_mask);
                  error_count++;
               end
               if (rsp_chosen_column !== arrived_pick.chosen_column) begin
                  $display("%0t: chosen_column expected %0d, got %0d",
                           $time, arrived_pick.chosen_column, rsp_chosen_column);
                  error_count++;
               end
               if (rsp_row_used !== arrived_pick.row_used) begin
                  $display("%0t: row_used expected %0d, got %0d",
                           $time, arrived_pick.row_used, rsp_row_used);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
         $display("tb_probabilistic_logic_gate: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic gate_item_type load_item(input logic [3:0] r, input logic [3:0] c,
                                               input logic [7:0] w);
      gate_item_type item;
      item.op          = plg_pkg::OP_LOAD;
      item.node_states = $urandom;
      item.random_draw = 31'($urandom);
      item.load_row    = r;
      item.load_column = c;
      item.load_weight = w;
      return item;
   endfunction

   function automatic gate_item_type eval_item(input logic [31:0] states,
                                               input logic [30:0] draw);
      gate_item_type item;
      item.op          = plg_pkg::OP_EVALUATE;
      item.node_states = states;
      item.random_draw = draw;
      item.load_row    = 4'($urandom);
      item.load_column = 4'($urandom);
      item.load_weight = 8'($urandom);
      return item;
   endfunction

   function automatic gate_item_type random_item();
      logic [7:0] w;
      if ($urandom_range(99) < 40) begin
         case ($urandom_range(9))
            0:       w = 8'd0;
            1:       w = 8'd255;
            default: w = 8'($urandom);
         endcase
         return load_item(4'($urandom), 4'($urandom), w);
      end
      // Small draws land near the prefix-sum boundaries of a row.
      if ($urandom_range(99) < 30) return eval_item($urandom, 31'($urandom_range(4095)));
      return eval_item($urandom, 31'($urandom));
   endfunction

   task automatic write_reg(input logic [plg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [plg_pkg::LIST_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Only called while the gate is idle, so the shadow copy updates at once.
   task automatic configure(input logic [2:0] n_in, input logic [2:0] n_out,
                            input logic [19:0] in_list, input logic [19:0] out_list);
      write_reg(plg_pkg::CSR_INPUT_COUNT,      {17'($urandom), n_in});
      write_reg(plg_pkg::CSR_OUTPUT_COUNT,     {17'($urandom), n_out});
      write_reg(plg_pkg::CSR_INPUT_NODE_LIST,  in_list);
      write_reg(plg_pkg::CSR_OUTPUT_NODE_LIST, out_list);
      @(posedge clock);
      csr_write <= 1'b0;
      in_count_cfg  = n_in;
      out_count_cfg = n_out;
      in_list_cfg   = in_list;
      out_list_cfg  = out_list;
      setting_count++;
   endtask

   // Waits until every queued item is accepted and every result has come back.
   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || picks_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [2:0]  seg_in [8];
      logic [2:0]  seg_out [8];
      logic [19:0] seg_in_list [8];
      logic [19:0] seg_out_list [8];
      foreach (weight_shadow[r, c]) weight_shadow[r][c] = 8'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: first input node is 31, outputs go to nodes 0, 31, 8, 15.
      configure(3'd4, 3'd4, {5'd7, 5'd16, 5'd0, 5'd31}, {5'd15, 5'd8, 5'd31, 5'd0});
      queue_item(load_item(4'd0, 4'd0, 8'd255));
      queue_item(load_item(4'd0, 4'd15, 8'd255));
      queue_item(load_item(4'd15, 4'd15, 8'd0));
      queue_item(load_item(4'd15, 4'd0, 8'd0));
      queue_item(load_item(4'd8, 4'd3, 8'd200));
      // Row 0 now sums to 524: probe zero, the first boundary and the last column.
      queue_item(eval_item(32'h0, 31'd0));
      queue_item(eval_item(32'h0, 31'd255));
      queue_item(eval_item(32'h0, 31'd256));
      queue_item(eval_item(32'h0, 31'd523));
      queue_item(eval_item(32'h0, 31'd524));
      queue_item(eval_item(32'h0, 31'h7FFF_FFFF));
      queue_item(eval_item(32'hFFFF_FFFF, 31'd0));
      queue_item(eval_item(32'hFFFF_FFFF, 31'h7FFF_FFFF));
      queue_item(eval_item(32'h8000_0000, 31'd215));
      queue_item(eval_item(32'h8000_0000, 31'd216));
      queue_item(eval_item(32'h0000_0080, 31'($urandom)));
      queue_item(eval_item(32'h0001_0001, 31'($urandom)));
      drain();

      // Settings cover counts below, inside and above range plus duplicate nodes.
      seg_in  = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5};
      seg_out = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd6};
      seg_in_list  = '{20'($urandom), 20'h0, 20'($urandom), 20'($urandom),
                       20'($urandom), {4{5'd31}}, 20'hFFFFF, 20'($urandom)};
      seg_out_list = '{20'($urandom), 20'h0, 20'($urandom), 20'($urandom),
                       {4{5'd5}}, {5'd31, 5'd31, 5'd3, 5'd3}, 20'hFFFFF, 20'($urandom)};
      for (int seg = 0; seg < 8; seg++) begin
         if (seg < 3) begin
            sender_idle_pct   = 23;
            receiver_idle_pct = 88;
         end else if (seg < 6) begin
            sender_idle_pct   = 88;
            receiver_idle_pct = 23;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         configure(seg_in[seg], seg_out[seg], seg_in_list[seg], seg_out_list[seg]);
         for (int half = 0; half < 2; half++) begin
            for (int n = 0; n < SEGMENT_ITEMS / 2; n++) queue_item(random_item());
            // Block the output while the sender keeps offering.
            if (half == 0 && (seg == 1 || seg == 6)) holds_asked++;
            drain();
         end
      end

      repeat (150) @(posedge clock);
      if (picks_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, picks_due.size());
         error_count++;
      end
      $display("Run covered %0d evaluates and %0d table loads over %0d register settings,",
               eval_count, load_count, setting_count);
      $display("with %0d long output hold-offs and %0d failures.", holds_served, error_count);
      if (error_count == 0) begin
         $display("tb_probabilistic_logic_gate: clean");
      end else begin
         $display("tb_probabilistic_logic_gate: errors");
      end
      $finish;
   end

endmodule
